@@ rtl/fixed_point_alu_macros.svh @@
// Assertion macros used by the ALU module.
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FPA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
package fpa_pkg;
	typedef enum logic [3:0] {
		ACT_ADD = 4'd0, ACT_SUB = 4'd1, ACT_MUL = 4'd2, ACT_DIV = 4'd3,
		ACT_GT = 4'd4, ACT_LT = 4'd5, ACT_GE = 4'd6, ACT_LE = 4'd7,
		ACT_EQ = 4'd8, ACT_NE = 4'd9, ACT_MIN = 4'd10, ACT_MAX = 4'd11,
		ACT_INC = 4'd12, ACT_DEC = 4'd13, ACT_I2F = 4'd14, ACT_F2I = 4'd15
	} action_t;

	localparam int DATA_W = 32;

	// Control state carried from cell to cell alongside the data.
	typedef struct packed {
		logic                     vld;
		logic                     neg;
		logic                     is_div;
		logic                     dz;
		logic                     cmp;
		logic                     sat;
		logic signed [DATA_W-1:0] val;
	} ctl_t;
endpackage

@@ rtl/fixed_point_alu.sv @@
`timescale 1ns / 1ps
// Stages for every action (DIV_STEPS = 32 + FRAC_BITS + 1):
// the decode register, the chain of restoring divider cells with one quotient bit per
// cell, the rounding register and the output register.
// Throughput: one transfer per cycle; the whole pipe advances when the output is free.
// Reset: arst_n asynchronously clears all valid bits; payload registers are not reset.
module fixed_point_alu #(
	parameter int FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [3:0]                       action,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [fpa_pkg::DATA_W-1:0] result_value,
	output logic                             compare_true,
	output logic                             divide_by_zero,
	output logic                             saturated
);
	import fpa_pkg::*;
	`include "fixed_point_alu_macros.svh"

	// The quotient a*2^F/b needs up to 32+F bits; one extra step yields the
	// half bit used for rounding, so we compute floor(a*2^(F+1)/b).
	localparam int NUM_W     = DATA_W + FRAC_BITS + 1;
	localparam int DIV_STEPS = NUM_W;
	localparam int REM_W     = DATA_W + 1;
	localparam int PROD_W    = 2 * DATA_W;

	// The pipe moves as one; it stalls only when a finished result is blocked.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	logic accept;
	assign accept = in_valid && in_ready;

	// ---------------------------------------------------------------- stage 1
	// Decode, magnitudes, and all actions other than multiply and divide are settled here.
	logic signed [DATA_W:0] a_x, b_x;
	logic [DATA_W-1:0]      mag_a, mag_b;
	logic signed [DATA_W+1:0] sum_w;
	logic signed [DATA_W-1:0] max_v, min_v;
	logic signed [DATA_W+FRAC_BITS:0] i2f_w;
	ctl_t                   ctl_c;
	action_t                act;

	assign max_v = {1'b0, {(DATA_W-1){1'b1}}};
	assign min_v = {1'b1, {(DATA_W-1){1'b0}}};

	always_comb begin
		act   = action_t'(action);
		a_x   = {operand_a[DATA_W-1], operand_a};
		b_x   = {operand_b[DATA_W-1], operand_b};
		mag_a = operand_a[DATA_W-1] ? DATA_W'(-a_x) : operand_a;
		mag_b = operand_b[DATA_W-1] ? DATA_W'(-b_x) : operand_b;
		sum_w = '0;
		i2f_w = {{(FRAC_BITS+1){operand_a[DATA_W-1]}}, operand_a} <<< FRAC_BITS;
		ctl_c = '0;
		ctl_c.vld    = accept;
		ctl_c.neg    = operand_a[DATA_W-1] ^ operand_b[DATA_W-1];
		ctl_c.is_div = 1'b0;
		unique case (act)
			ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
				unique case (act)
					ACT_ADD: sum_w = (DATA_W+2)'(a_x) + (DATA_W+2)'(b_x);
					ACT_SUB: sum_w = (DATA_W+2)'(a_x) - (DATA_W+2)'(b_x);
					ACT_INC: sum_w = (DATA_W+2)'(a_x) + (DATA_W+2)'(1);
					default: sum_w = (DATA_W+2)'(a_x) - (DATA_W+2)'(1);
				endcase
				if (sum_w > (DATA_W+2)'(max_v)) begin
					ctl_c.val = max_v;
					ctl_c.sat = 1'b1;
				end else if (sum_w < (DATA_W+2)'(min_v)) begin
					ctl_c.val = min_v;
					ctl_c.sat = 1'b1;
				end else begin
					ctl_c.val = sum_w[DATA_W-1:0];
				end
			end
			ACT_MUL: ctl_c.val = '0;
			ACT_DIV: begin
				ctl_c.is_div = 1'b1;
				ctl_c.dz     = (operand_b == '0);
			end
			ACT_GT: ctl_c.cmp = operand_a > operand_b;
			ACT_LT: ctl_c.cmp = operand_a < operand_b;
			ACT_GE: ctl_c.cmp = operand_a >= operand_b;
			ACT_LE: ctl_c.cmp = operand_a <= operand_b;
			ACT_EQ: ctl_c.cmp = operand_a == operand_b;
			ACT_NE: ctl_c.cmp = operand_a != operand_b;
			ACT_MIN: ctl_c.val = (operand_a <= operand_b) ? operand_a : operand_b;
			ACT_MAX: ctl_c.val = (operand_a >= operand_b) ? operand_a : operand_b;
			ACT_I2F: begin
				if (i2f_w > (DATA_W+FRAC_BITS+1)'(max_v)) begin
					ctl_c.val = max_v;
					ctl_c.sat = 1'b1;
				end else if (i2f_w < (DATA_W+FRAC_BITS+1)'(min_v)) begin
					ctl_c.val = min_v;
					ctl_c.sat = 1'b1;
				end else begin
					ctl_c.val = i2f_w[DATA_W-1:0];
				end
			end
			default: ctl_c.val = operand_a >>> FRAC_BITS;
		endcase
	end

	ctl_t                ctl_s1;
	logic                is_mul_s1;
	logic [DATA_W-1:0]   mag_a_s1, mag_b_s1;

	// A divide by zero gets a unit divisor so the chain stays well defined;
	// the multiplier must still see the true zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.vld <= 1'b0;
		end else if (en) begin
			ctl_s1    <= ctl_c;
			is_mul_s1 <= (act == ACT_MUL);
			mag_a_s1  <= mag_a;
			mag_b_s1  <= (act == ACT_DIV && operand_b == '0) ? DATA_W'(1) : mag_b;
		end
	end

	// The 32x32 product is registered alongside the first chain cell and then rides
	// along the chain in delay registers, so only one multiplier exists.
	logic [PROD_W-1:0] prod_s2;
	logic              is_mul_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2   <= PROD_W'(mag_a_s1) * PROD_W'(mag_b_s1);
			is_mul_s2 <= is_mul_s1;
		end
	end

	// ----------------------------------------------------------- divider chain
	// Each cell produces one quotient bit of floor(|a| * 2^(F+1) / |b|).
	ctl_t             ctl_ch [DIV_STEPS+1];
	logic [REM_W-1:0] rem_ch [DIV_STEPS+1];
	logic [NUM_W-1:0] num_ch [DIV_STEPS+1];
	logic [NUM_W-1:0] quo_ch [DIV_STEPS+1];
	logic [REM_W-1:0] den_ch [DIV_STEPS+1];

	assign ctl_ch[0] = ctl_s1;
	assign rem_ch[0] = '0;
	assign num_ch[0] = {mag_a_s1, (FRAC_BITS+1)'(0)};
	assign quo_ch[0] = '0;
	assign den_ch[0] = {1'b0, mag_b_s1};

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		fpa_div_cell #(
			.REM_W(REM_W),
			.NUM_W(NUM_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (ctl_ch[i]),
			.rem_in (rem_ch[i]),
			.num_in (num_ch[i]),
			.quo_in (quo_ch[i]),
			.den_in (den_ch[i]),
			.ctl_out(ctl_ch[i+1]),
			.rem_out(rem_ch[i+1]),
			.num_out(num_ch[i+1]),
			.quo_out(quo_ch[i+1]),
			.den_out(den_ch[i+1])
		);
	end

	// The product is delayed to line up with the end of the chain.
	localparam int PDLY = DIV_STEPS - 1;
	logic [PROD_W-1:0] prod_d [PDLY+1];
	logic              mul_d  [PDLY+1];
	assign prod_d[0] = prod_s2;
	assign mul_d[0]  = is_mul_s2;

	for (genvar j = 0; j < PDLY; j++) begin : g_pdly
		always_ff @(posedge clk) begin
			if (en) begin
				prod_d[j+1] <= prod_d[j];
				mul_d[j+1]  <= mul_d[j];
			end
		end
	end

	// -------------------------------------------------------------- rounding
	// Round half away from zero on the magnitude, then register.
	ctl_t             ctl_e;
	logic [NUM_W-1:0] qmag;
	logic [PROD_W:0]  pmag;
	ctl_t             ctl_r1;
	logic [PROD_W:0]  rmag_r1;
	logic             arith_r1;

	always_comb begin
		ctl_e = ctl_ch[DIV_STEPS];
		qmag  = quo_ch[DIV_STEPS] + NUM_W'(1);
		pmag  = ((PROD_W+1)'(prod_d[PDLY]) + ((PROD_W+1)'(1) << (FRAC_BITS - 1)))
			>> FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_r1.vld <= 1'b0;
		end else if (en) begin
			ctl_r1   <= ctl_e;
			arith_r1 <= (ctl_e.is_div && !ctl_e.dz) || mul_d[PDLY];
			rmag_r1  <= ctl_e.is_div ? (PROD_W+1)'(qmag[NUM_W-1:1]) : pmag;
		end
	end

	// ---------------------------------------------------------- saturation
	// A negative magnitude may reach 2^31; anything above saturates.
	logic                     ovf_pos, ovf_neg;
	logic signed [DATA_W-1:0] fin_val;
	logic                     fin_sat;

	always_comb begin
		ovf_pos = rmag_r1 > (PROD_W+1)'(max_v);
		ovf_neg = rmag_r1 > (PROD_W+1)'(max_v) + (PROD_W+1)'(1);
		fin_val = ctl_r1.val;
		fin_sat = ctl_r1.sat;
		if (arith_r1) begin
			if (ctl_r1.neg) begin
				fin_val = ovf_neg ? min_v : -DATA_W'(rmag_r1[DATA_W-1:0]);
				fin_sat = ovf_neg;
			end else begin
				fin_val = ovf_pos ? max_v : rmag_r1[DATA_W-1:0];
				fin_sat = ovf_pos;
			end
		end
	end

	// Output register: holds a result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= ctl_r1.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_value   <= fin_val;
			compare_true   <= ctl_r1.cmp;
			divide_by_zero <= ctl_r1.dz;
			saturated      <= fin_sat;
		end
	end

	`FPA_ASSERT_IMP(a_flags_excl, out_valid, !(divide_by_zero && saturated), "dz and sat together")
	`FPA_ASSERT_IMP(a_dz_zero, out_valid && divide_by_zero, result_value == '0, "dz nonzero result")
	`FPA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_value),
		"result changed while stalled")
endmodule

@@ rtl/fpa_div_cell.sv @@
`timescale 1ns / 1ps
module fpa_div_cell #(
	parameter int REM_W = 34,
	parameter int NUM_W = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  fpa_pkg::ctl_t       ctl_in,
	input  logic [REM_W-1:0]    rem_in,
	input  logic [NUM_W-1:0]    num_in,
	input  logic [NUM_W-1:0]    quo_in,
	input  logic [REM_W-1:0]    den_in,
	output fpa_pkg::ctl_t       ctl_out,
	output logic [REM_W-1:0]    rem_out,
	output logic [NUM_W-1:0]    num_out,
	output logic [NUM_W-1:0]    quo_out,
	output logic [REM_W-1:0]    den_out
);
	import fpa_pkg::*;

	logic [REM_W-1:0] trial;
	logic [REM_W:0]   diff;
	logic             fits;

	// One restoring division step: shift in a numerator bit, try a subtract.
	always_comb begin
		trial = {rem_in[REM_W-2:0], num_in[NUM_W-1]};
		diff  = {1'b0, trial} - {1'b0, den_in};
		fits  = !diff[REM_W];
	end

	// Only the valid bit is cleared by reset; the payload just holds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out.vld <= 1'b0;
		end else if (en) begin
			ctl_out <= ctl_in;
			rem_out <= fits ? diff[REM_W-1:0] : trial;
			num_out <= {num_in[NUM_W-2:0], 1'b0};
			quo_out <= {quo_in[NUM_W-2:0], fits};
			den_out <= den_in;
		end
	end
endmodule
